// ===== rtl/ile_pkg.sv =====
package ile_pkg;

   localparam int Depth   = 64;
   localparam int Width   = 32;
   localparam int AddrW   = $clog2(Depth);
   localparam int CountW  = AddrW + 1;

   // position meaning the last entry
   localparam logic signed [CountW:0] PosLast = '1;

   typedef enum logic [2:0] {
      FUNC_APPEND     = 3'd0,
      FUNC_INSERT     = 3'd1,
      FUNC_POP        = 3'd2,
      FUNC_READ       = 3'd3,
      FUNC_COUNT      = 3'd4,
      FUNC_PALINDROME = 3'd5,
      FUNC_REVERSE    = 3'd6,
      FUNC_CLEAR      = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_POP_GET,
      S_SHL_RD,
      S_SHL_WR,
      S_RD_GET,
      S_CNT_RD,
      S_CNT_CHK,
      S_PR_A,
      S_PR_B,
      S_PR_C,
      S_PR_D,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [6:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [6:0]  match_count;
      logic        is_palindrome;
      logic [6:0]  occupancy;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ===== rtl/ile_ram.sv =====
module ile_ram #(
   parameter int DataW = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [DataW-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [DataW-1:0]         rd_data
);

   logic [DataW-1:0] mem [Depth];
   logic [DataW-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/indexed_list_engine_unit.sv =====
// append, clear and rejected commands go from decode straight to the result; read takes one RAM read;
// count, palindrome, reverse, insert and pop walk the list one entry or one pair at a time
// one transaction in flight: the next accept comes the cycle after the result is taken
// reset clears the fill count, the controller and the result valid; entry storage is not cleared
module indexed_list_engine_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ile_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ile_pkg::rsp_type rsp_data
);

   localparam int AW = ile_pkg::AddrW;
   localparam int CW = ile_pkg::CountW;

   ile_pkg::state_type  state_ff, state_in;
   ile_pkg::req_type    cmd_ff, cmd_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       i_ff, i_in, j_ff, j_in;
   logic [ile_pkg::Width-1:0] a_ff, a_in;
   logic [ile_pkg::Width-1:0] rdv_ff, rdv_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                pal_ff, pal_in;
   ile_pkg::status_type st_ff, st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ile_pkg::rsp_type    rsp_ff, rsp_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [ile_pkg::Width-1:0] wr_data, rd_data;

   logic signed [CW:0]  pos_s, n_s, neg_n_s, wrap_s;
   logic [CW-1:0]       fill_up, fill_dn, i_up, i_dn, j_dn;
   logic [AW-1:0]       read_idx, pop_idx;

   ile_ram #(.DataW(ile_pkg::Width), .Depth(ile_pkg::Depth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // signed index arithmetic and neighbors
   assign pos_s    = {cmd_ff.position[6], cmd_ff.position};
   assign n_s      = {1'b0, fill_ff};
   assign neg_n_s  = -n_s;
   assign wrap_s   = pos_s + n_s;
   assign fill_up  = fill_ff + CW'(1);
   assign fill_dn  = fill_ff - CW'(1);
   assign i_up     = i_ff + CW'(1);
   assign i_dn     = i_ff - CW'(1);
   assign j_dn     = j_ff - CW'(1);
   assign read_idx = pos_s[CW] ? wrap_s[AW-1:0] : pos_s[AW-1:0];
   assign pop_idx  = (pos_s == ile_pkg::PosLast) ? fill_dn[AW-1:0] : pos_s[AW-1:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ile_pkg::S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      a_ff   <= a_in;
      rdv_ff <= rdv_in;
      cnt_ff <= cnt_in;
      pal_ff <= pal_in;
      st_ff  <= st_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ile_pkg::S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      fill_in      = fill_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      rdv_in       = rdv_ff;
      cnt_in       = cnt_ff;
      pal_in       = pal_ff;
      st_in        = st_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = i_ff[AW-1:0];
      wr_data      = cmd_ff.value[ile_pkg::Width-1:0];
      rd_addr      = i_ff[AW-1:0];
      unique case (state_ff)
         ile_pkg::S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               cmd_in   = req_data;
               state_in = ile_pkg::S_DECODE;
            end
         end
         // decode and range checks, set up the walk
         ile_pkg::S_DECODE: begin
            rdv_in   = '0;
            cnt_in   = '0;
            pal_in   = (cmd_ff.func == ile_pkg::FUNC_PALINDROME);
            st_in    = ile_pkg::ST_OK;
            state_in = ile_pkg::S_DONE;
            unique case (ile_pkg::func_type'(cmd_ff.func)) inside
               ile_pkg::FUNC_APPEND: begin
                  if (fill_ff == CW'(ile_pkg::Depth)) begin
                     st_in = ile_pkg::ST_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = fill_ff[AW-1:0];
                     fill_in = fill_up;
                  end
               end
               ile_pkg::FUNC_INSERT: begin
                  if (pos_s[CW] || pos_s >= n_s) begin
                     st_in = ile_pkg::ST_RANGE;
                  end else if (fill_ff == CW'(ile_pkg::Depth)) begin
                     st_in = ile_pkg::ST_FULL;
                  end else begin
                     // walk down from the tail, i is the source index
                     i_in     = fill_dn;
                     j_in     = {1'b0, pos_s[AW-1:0]};
                     state_in = ile_pkg::S_INS_RD;
                  end
               end
               ile_pkg::FUNC_POP: begin
                  if (fill_ff == '0) begin
                     st_in = ile_pkg::ST_EMPTY;
                  end else if (pos_s < ile_pkg::PosLast || pos_s >= n_s) begin
                     st_in = ile_pkg::ST_RANGE;
                  end else begin
                     rd_addr  = pop_idx;
                     i_in     = {1'b0, pop_idx};
                     state_in = ile_pkg::S_POP_GET;
                  end
               end
               ile_pkg::FUNC_READ: begin
                  if (pos_s >= n_s || pos_s < neg_n_s) begin
                     st_in = ile_pkg::ST_RANGE;
                  end else begin
                     rd_addr  = read_idx;
                     state_in = ile_pkg::S_RD_GET;
                  end
               end
               ile_pkg::FUNC_COUNT: begin
                  i_in = '0;
                  if (fill_ff != '0) begin
                     state_in = ile_pkg::S_CNT_RD;
                  end
               end
               ile_pkg::FUNC_PALINDROME, ile_pkg::FUNC_REVERSE: begin
                  i_in = '0;
                  j_in = fill_dn;
                  if (fill_ff > CW'(1)) begin
                     state_in = ile_pkg::S_PR_A;
                  end
               end
               ile_pkg::FUNC_CLEAR: begin
                  fill_in = '0;
               end
            endcase
         end
         // insert: read entry i
         ile_pkg::S_INS_RD: begin
            state_in = ile_pkg::S_INS_WR;
         end
         // insert: move entry i up to i+1
         ile_pkg::S_INS_WR: begin
            wr_en   = 1'b1;
            wr_addr = i_up[AW-1:0];
            wr_data = rd_data;
            if (i_ff == j_ff) begin
               state_in = ile_pkg::S_INS_PUT;
            end else begin
               i_in     = i_dn;
               state_in = ile_pkg::S_INS_RD;
            end
         end
         // insert: place the value at its index
         ile_pkg::S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[AW-1:0];
            fill_in  = fill_up;
            state_in = ile_pkg::S_DONE;
         end
         // pop: latch the popped word
         ile_pkg::S_POP_GET: begin
            rdv_in   = rd_data;
            state_in = ile_pkg::S_SHL_RD;
         end
         // pop: read the next entry or finish
         ile_pkg::S_SHL_RD: begin
            if (i_up >= fill_ff) begin
               fill_in  = fill_dn;
               state_in = ile_pkg::S_DONE;
            end else begin
               rd_addr  = i_up[AW-1:0];
               state_in = ile_pkg::S_SHL_WR;
            end
         end
         // pop: move entry i+1 down to i
         ile_pkg::S_SHL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[AW-1:0];
            wr_data  = rd_data;
            i_in     = i_up;
            state_in = ile_pkg::S_SHL_RD;
         end
         // read: latch the word
         ile_pkg::S_RD_GET: begin
            rdv_in   = rd_data;
            state_in = ile_pkg::S_DONE;
         end
         ile_pkg::S_CNT_RD: begin
            state_in = ile_pkg::S_CNT_CHK;
         end
         // count: compare one entry
         ile_pkg::S_CNT_CHK: begin
            if (rd_data == cmd_ff.value[ile_pkg::Width-1:0]) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (i_up >= fill_ff) begin
               state_in = ile_pkg::S_DONE;
            end else begin
               i_in     = i_up;
               state_in = ile_pkg::S_CNT_RD;
            end
         end
         // pair walk: read i, then j
         ile_pkg::S_PR_A: begin
            state_in = ile_pkg::S_PR_B;
         end
         ile_pkg::S_PR_B: begin
            a_in     = rd_data;
            rd_addr  = j_ff[AW-1:0];
            state_in = ile_pkg::S_PR_C;
         end
         // pair walk: compare, or write word j to i
         ile_pkg::S_PR_C: begin
            if (cmd_ff.func == ile_pkg::FUNC_PALINDROME) begin
               if (rd_data != a_ff) begin
                  pal_in   = 1'b0;
                  state_in = ile_pkg::S_DONE;
               end else if (i_up >= j_dn) begin
                  state_in = ile_pkg::S_DONE;
               end else begin
                  i_in     = i_up;
                  j_in     = j_dn;
                  state_in = ile_pkg::S_PR_A;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = i_ff[AW-1:0];
               wr_data  = rd_data;
               state_in = ile_pkg::S_PR_D;
            end
         end
         // reverse: word i goes to j
         ile_pkg::S_PR_D: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = a_ff;
            if (i_up >= j_dn) begin
               state_in = ile_pkg::S_DONE;
            end else begin
               i_in     = i_up;
               j_in     = j_dn;
               state_in = ile_pkg::S_PR_A;
            end
         end
         // build the result transaction
         ile_pkg::S_DONE: begin
            rsp_in.read_value    = rdv_ff;
            rsp_in.match_count   = cnt_ff;
            rsp_in.is_palindrome = pal_ff;
            rsp_in.occupancy     = fill_ff;
            rsp_in.status        = st_ff;
            rsp_valid_in         = 1'b1;
            state_in             = ile_pkg::S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   // occupancy never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(ile_pkg::Depth))
      else $error("fill count overflow");
   // accept only from idle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ile_pkg::S_DECODE)
      else $error("accept outside idle");
   // no command runs while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ile_pkg::S_IDLE |-> !rsp_valid)
      else $error("busy with result pending");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int ItemCount  = 1200;
   localparam int QuietLimit = 20000;

   // one directed row: command plus optional typed-in answer
   typedef struct {
      ile_pkg::func_type func;
      int                position;
      logic [31:0]       value;
      bit                fixed;
      ile_pkg::rsp_type  answer;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ile_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ile_pkg::rsp_type rsp_data;

   // predictor copy of the list
   logic [31:0]      list_words [ile_pkg::Depth];
   int               list_size = 0;
   ile_pkg::rsp_type expected_rsps [$];
   int               errors = 0;
   int               quiet_cycles = 0;
   bit               hold_rsp = 1'b0;
   bit               calm = 1'b0;
   row_type          rows [$];

   indexed_list_engine_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // list behavior for one command
   function automatic ile_pkg::rsp_type list_apply(ile_pkg::req_type cmd);
      ile_pkg::rsp_type r;
      int               pos;
      int               i;
      logic [31:0]      t;
      r = '0;
      r.status = ile_pkg::ST_OK;
      pos = int'($signed(cmd.position));
      case (ile_pkg::func_type'(cmd.func))
         ile_pkg::FUNC_APPEND: begin
            if (list_size >= ile_pkg::Depth) r.status = ile_pkg::ST_FULL;
            else begin
               list_words[list_size] = cmd.value;
               list_size++;
            end
         end
         ile_pkg::FUNC_INSERT: begin
            if (pos < 0 || pos >= list_size) r.status = ile_pkg::ST_RANGE;
            else if (list_size >= ile_pkg::Depth) r.status = ile_pkg::ST_FULL;
            else begin
               for (i = list_size - 1; i >= pos; i--) list_words[i + 1] = list_words[i];
               list_words[pos] = cmd.value;
               list_size++;
            end
         end
         ile_pkg::FUNC_POP: begin
            if (list_size == 0) r.status = ile_pkg::ST_EMPTY;
            else if (pos < -1 || pos >= list_size) r.status = ile_pkg::ST_RANGE;
            else begin
               if (pos == -1) pos = list_size - 1;
               r.read_value = list_words[pos];
               for (i = pos; i < list_size - 1; i++) list_words[i] = list_words[i + 1];
               list_size--;
            end
         end
         ile_pkg::FUNC_READ: begin
            if (pos >= list_size || pos < -list_size) r.status = ile_pkg::ST_RANGE;
            else begin
               if (pos < 0) pos += list_size;
               r.read_value = list_words[pos];
            end
         end
         ile_pkg::FUNC_COUNT: begin
            for (i = 0; i < list_size; i++)
               if (list_words[i] == cmd.value) r.match_count++;
         end
         ile_pkg::FUNC_PALINDROME: begin
            r.is_palindrome = 1'b1;
            for (i = 0; i < list_size / 2; i++)
               if (list_words[i] != list_words[list_size - 1 - i]) r.is_palindrome = 1'b0;
         end
         ile_pkg::FUNC_REVERSE: begin
            for (i = 0; i < list_size / 2; i++) begin
               t = list_words[i];
               list_words[i] = list_words[list_size - 1 - i];
               list_words[list_size - 1 - i] = t;
            end
         end
         default: list_size = 0;
      endcase
      r.occupancy = 7'(list_size);
      return r;
   endfunction

   // drive one transaction at the falling edge, hold until accepted
   task automatic send_cmd(ile_pkg::req_type cmd);
      while (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= cmd;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic ile_pkg::req_type make_cmd(ile_pkg::func_type f, int p, logic [31:0] v);
      ile_pkg::req_type c;
      c.func = f;
      c.position = 7'(p);
      c.value = v;
      return c;
   endfunction

   function automatic void add_row(ile_pkg::func_type f, int p, logic [31:0] v, bit fx,
                                   logic [31:0] rv, int occ, ile_pkg::status_type st);
      row_type rw;
      rw.func = f;
      rw.position = p;
      rw.value = v;
      rw.fixed = fx;
      rw.answer = '0;
      rw.answer.read_value = rv;
      rw.answer.occupancy = 7'(occ);
      rw.answer.status = st;
      rows.push_back(rw);
   endfunction

   // random position biased to the interesting range
   function automatic int pick_pos();
      int r;
      r = $urandom_range(9);
      if (r < 6) return $urandom_range(list_size > 0 ? list_size - 1 : 0);
      if (r == 6) return -1;
      if (r == 7) return -$urandom_range(list_size > 0 ? list_size : 1);
      return int'($urandom_range(127)) - 64;
   endfunction

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transaction %p", $time, rsp_data);
            errors++;
         end else begin
            ile_pkg::rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data.read_value !== e.read_value ||
                rsp_data.match_count !== e.match_count ||
                rsp_data.is_palindrome !== e.is_palindrome ||
                rsp_data.occupancy !== e.occupancy ||
                rsp_data.status !== e.status) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (calm) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 8);
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (!reset);
      repeat (400) @(negedge clock);
      hold_rsp = 1'b1;
      repeat (300) @(negedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      ile_pkg::req_type cmd;
      ile_pkg::rsp_type exp_rsp;
      int               n;
      int               f;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      add_row(ile_pkg::FUNC_POP, 0, 0, 1, 0, 0, ile_pkg::ST_EMPTY);
      add_row(ile_pkg::FUNC_READ, 0, 0, 1, 0, 0, ile_pkg::ST_RANGE);
      add_row(ile_pkg::FUNC_READ, -1, 0, 1, 0, 0, ile_pkg::ST_RANGE);
      add_row(ile_pkg::FUNC_PALINDROME, 0, 0, 0, 0, 0, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_COUNT, 0, 0, 1, 0, 0, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_REVERSE, 0, 0, 1, 0, 0, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_INSERT, 0, 32'h5, 1, 0, 0, ile_pkg::ST_RANGE);
      add_row(ile_pkg::FUNC_APPEND, 0, 32'hFFFF_FFFF, 1, 0, 1, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_APPEND, 63, 32'h0, 1, 0, 2, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_INSERT, 2, 32'h1, 1, 0, 2, ile_pkg::ST_RANGE);
      add_row(ile_pkg::FUNC_INSERT, 0, 32'hA5A5_5A5A, 0, 0, 0, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_READ, -3, 0, 1, 32'hA5A5_5A5A, 3, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_READ, -64, 0, 1, 0, 3, ile_pkg::ST_RANGE);
      add_row(ile_pkg::FUNC_READ, 63, 0, 1, 0, 3, ile_pkg::ST_RANGE);
      add_row(ile_pkg::FUNC_POP, -2, 0, 1, 0, 3, ile_pkg::ST_RANGE);
      add_row(ile_pkg::FUNC_POP, 3, 0, 1, 0, 3, ile_pkg::ST_RANGE);
      add_row(ile_pkg::FUNC_POP, -1, 0, 1, 32'h0, 2, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_APPEND, 0, 32'hA5A5_5A5A, 0, 0, 0, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_PALINDROME, 0, 0, 0, 0, 0, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_COUNT, 0, 32'hA5A5_5A5A, 0, 0, 0, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_REVERSE, 0, 0, 0, 0, 0, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_POP, 0, 0, 0, 0, 0, ile_pkg::ST_OK);
      add_row(ile_pkg::FUNC_CLEAR, 0, 0, 1, 0, 0, ile_pkg::ST_OK);
      foreach (rows[k]) begin
         cmd = make_cmd(rows[k].func, rows[k].position, rows[k].value);
         exp_rsp = list_apply(cmd);
         if (rows[k].fixed && exp_rsp !== rows[k].answer) begin
            $display("%0t: directed row %0d expected %p actual %p", $time, k,
                     rows[k].answer, exp_rsp);
            errors++;
         end
         expected_rsps.push_back(rows[k].fixed ? rows[k].answer : exp_rsp);
         send_cmd(cmd);
      end

      // fill to capacity, hit full, then pop at random positions and reverse
      for (n = 0; n < ile_pkg::Depth + 2; n++) begin
         cmd = make_cmd(n % 2 ? ile_pkg::FUNC_APPEND : ile_pkg::FUNC_INSERT, 0, $urandom());
         if (list_size == 0) cmd.func = ile_pkg::FUNC_APPEND;
         expected_rsps.push_back(list_apply(cmd));
         send_cmd(cmd);
      end
      for (n = 0; n < ile_pkg::Depth + 2; n++) begin
         cmd = make_cmd(n % 3 == 0 ? ile_pkg::FUNC_REVERSE : ile_pkg::FUNC_POP, pick_pos(),
                        $urandom());
         expected_rsps.push_back(list_apply(cmd));
         send_cmd(cmd);
      end

      // random mix, small value set so count and palindrome see matches
      for (n = 0; n < ItemCount; n++) begin
         calm = (n >= 600 && n < 750);
         f = $urandom_range(99);
         if (f < 30) cmd.func = ile_pkg::FUNC_APPEND;
         else if (f < 45) cmd.func = ile_pkg::FUNC_INSERT;
         else if (f < 62) cmd.func = ile_pkg::FUNC_POP;
         else if (f < 75) cmd.func = ile_pkg::FUNC_READ;
         else if (f < 83) cmd.func = ile_pkg::FUNC_COUNT;
         else if (f < 90) cmd.func = ile_pkg::FUNC_PALINDROME;
         else if (f < 98) cmd.func = ile_pkg::FUNC_REVERSE;
         else cmd.func = ile_pkg::FUNC_CLEAR;
         cmd.position = 7'(pick_pos());
         cmd.value = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(3));
         expected_rsps.push_back(list_apply(cmd));
         send_cmd(cmd);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ile_pkg.sv
rtl/ile_ram.sv
rtl/indexed_list_engine_unit.sv
tb/testbench.sv
